FILE: hw/rtl/sactp_pkg.sv
// ----------------------------------------------------------------------------
// sactp_pkg
// shared types and constants of the cache tag store with tree pseudo-lru
// ----------------------------------------------------------------------------
package sactp_pkg;

  localparam int ADDR_W     = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int VTAG_W     = 20;
  localparam int CNT_W      = 32;
  // widest tree: eight ways need seven node bits
  localparam int TREE_MAX_W = 7;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } sactp_req_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic                 victim_valid;
    logic                 victim_dirty;
    logic [VTAG_W-1:0]    victim_tag;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
  } sactp_rsp_t;

endpackage

FILE: hw/rtl/sactp_store.sv
// ----------------------------------------------------------------------------
// sactp_store
// per-set row memories for tags and for valid, dirty and tree bits
// ----------------------------------------------------------------------------
module sactp_store #(
  parameter int SETS   = 64,
  parameter int WAYS   = 4,
  parameter int TAG_W  = 20,
  parameter int IDX_W  = 6,
  parameter int TREE_W = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  logic [WAYS*TAG_W-1:0] wr_tags_i,
  input  logic [WAYS-1:0]       wr_valid_i,
  input  logic [WAYS-1:0]       wr_dirty_i,
  input  logic [TREE_W-1:0]     wr_tree_i,
  output logic [WAYS*TAG_W-1:0] rd_tags_o,
  output logic [WAYS-1:0]       rd_valid_o,
  output logic [WAYS-1:0]       rd_dirty_o,
  output logic [TREE_W-1:0]     rd_tree_o,
  output logic                  busy_o
);

  localparam int ST_W = 2 * WAYS + TREE_W;

  logic [WAYS*TAG_W-1:0] tag_mem [SETS];
  logic [ST_W-1:0]       st_mem  [SETS];

  logic [WAYS*TAG_W-1:0] rd_tags_q;
  logic [ST_W-1:0]       rd_st_q;

  logic                  clr_q;
  logic [IDX_W-1:0]      clr_idx_q;

  logic                  st_we;
  logic [IDX_W-1:0]      st_widx;
  logic [ST_W-1:0]       st_wdata;
  logic [ST_W-1:0]       wr_st;

  assign wr_st    = {wr_valid_i, wr_dirty_i, wr_tree_i};
  assign st_we    = clr_q | wr_en_i;
  assign st_widx  = clr_q ? clr_idx_q : wr_idx_i;
  assign st_wdata = clr_q ? '0 : wr_st;

  // clearing sweep of the state rows after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IDX_W'(SETS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // tag rows, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i && !clr_q) begin
      tag_mem[wr_idx_i] <= wr_tags_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
        rd_tags_q <= wr_tags_i;
      end else begin
        rd_tags_q <= tag_mem[rd_idx_i];
      end
    end
  end

  // state rows, write-first on a same-row read
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_widx] <= st_wdata;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
        rd_st_q <= wr_st;
      end else begin
        rd_st_q <= st_mem[rd_idx_i];
      end
    end
  end

  assign rd_tags_o  = rd_tags_q;
  assign rd_valid_o = rd_st_q[ST_W-1 -: WAYS];
  assign rd_dirty_o = rd_st_q[TREE_W +: WAYS];
  assign rd_tree_o  = rd_st_q[TREE_W-1:0];
  assign busy_o     = clr_q;

endmodule

FILE: hw/rtl/sactp_lookup.sv
// ----------------------------------------------------------------------------
// sactp_lookup
// tag compare, tree victim choice and row update for one set
// ----------------------------------------------------------------------------
module sactp_lookup
  import sactp_pkg::*;
#(
  parameter int WAYS   = 4,
  parameter int TAG_W  = 20,
  parameter int TREE_W = 3,
  parameter int WAY_W  = 2
) (
  input  logic [WAYS*TAG_W-1:0] tags_i,
  input  logic [WAYS-1:0]       valid_i,
  input  logic [WAYS-1:0]       dirty_i,
  input  logic [TREE_W-1:0]     tree_i,
  input  logic [TAG_W-1:0]      tag_i,
  input  logic                  command_i,
  output logic                  hit_o,
  output logic [WAY_W-1:0]      way_o,
  output logic                  victim_valid_o,
  output logic                  victim_dirty_o,
  output logic [TAG_W-1:0]      victim_tag_o,
  output logic [WAYS*TAG_W-1:0] tags_o,
  output logic [WAYS-1:0]       valid_o,
  output logic [WAYS-1:0]       dirty_o,
  output logic [TREE_W-1:0]     tree_o
);

  localparam int LVL  = $clog2(WAYS);
  localparam int SPAN = 1 << LVL;

  logic [WAYS-1:0]       match;
  logic                  hit;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      victim;
  logic [WAY_W-1:0]      sel;
  logic [TREE_MAX_W-1:0] t_in;
  logic [TREE_MAX_W-1:0] t_new;
  logic [3:0]            v_node, v_lo, v_half;
  logic                  v_up;
  logic [3:0]            u_node, u_lo, u_half;
  logic                  u_up;

  // parallel compare, lowest matching way wins
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_i[w] && (tags_i[w*TAG_W +: TAG_W] == tag_i);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign t_in = TREE_MAX_W'(tree_i);

  // victim walk, branches to absent ways are never taken
  always_comb begin
    v_node = 4'd1;
    v_lo   = '0;
    v_half = 4'(SPAN / 2);
    v_up   = 1'b0;
    for (int l = 0; l < LVL; l++) begin
      v_up = t_in[3'(v_node - 4'd1)];
      if ((v_lo + v_half) >= 4'(WAYS)) begin
        v_up = 1'b0;
      end
      if (v_up) begin
        v_lo = v_lo + v_half;
      end
      v_node = {v_node[2:0], v_up};
      v_half = v_half >> 1;
    end
    victim = WAY_W'(v_lo);
  end

  assign sel = hit ? hit_way : victim;

  // mark the used way most recent along its path
  always_comb begin
    t_new  = t_in;
    u_node = 4'd1;
    u_lo   = '0;
    u_half = 4'(SPAN / 2);
    u_up   = 1'b0;
    for (int l = 0; l < LVL; l++) begin
      u_up = ((4'(sel) - u_lo) >= u_half);
      t_new[3'(u_node - 4'd1)] = ~u_up;
      if (u_up) begin
        u_lo = u_lo + u_half;
      end
      u_node = {u_node[2:0], u_up};
      u_half = u_half >> 1;
    end
  end

  // new row contents
  always_comb begin
    tags_o  = tags_i;
    valid_o = valid_i;
    dirty_o = dirty_i;
    if (hit) begin
      if (command_i == CMD_WRITE) begin
        dirty_o[hit_way] = 1'b1;
      end
    end else begin
      tags_o[victim*TAG_W +: TAG_W] = tag_i;
      valid_o[victim]               = 1'b1;
      dirty_o[victim]               = (command_i == CMD_WRITE);
    end
  end

  assign hit_o          = hit;
  assign way_o          = sel;
  assign victim_valid_o = !hit && valid_i[victim];
  assign victim_dirty_o = !hit && valid_i[victim] && dirty_i[victim];
  assign victim_tag_o   = (!hit && valid_i[victim]) ? tags_i[victim*TAG_W +: TAG_W] : '0;
  assign tree_o         = TREE_W'(t_new);

endmodule

FILE: hw/rtl/set_assoc_cache_tag_plru_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_plru_unit
// write-back set-associative tag store with tree pseudo-lru replacement
// ----------------------------------------------------------------------------
// path: a request passes the request register, then the result register,
//   before its result is valid
// throughput: one transaction per cycle unless rsp_stall_i holds a result;
//   same-set accesses back to back use row memory write-first forwarding
// reset: counters clear at once; a sweep over all SETS rows then clears the
//   valid, dirty and tree rows, and req_stall_o stays high until it ends
module set_assoc_cache_tag_plru_unit
  import sactp_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int LINE_BYTES = 64,
  parameter int WAYS       = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_stall_o,
  input  sactp_req_t req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_stall_i,
  output sactp_rsp_t rsp_o
);

  // address split: offset, set index, tag
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(SETS);
  localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int TREE_W = (1 << WAY_W) - 1;

  // stage 1: request held while its set row comes out of the memories
  logic                  s1_valid_q;
  logic                  s1_cmd_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic [TAG_W-1:0]      s1_tag_q;
  logic                  s1_fire;

  // result register and running totals
  logic                  rsp_valid_q;
  sactp_rsp_t            rsp_q;
  logic [CNT_W-1:0]      hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]      miss_cnt_q, miss_cnt_d;

  logic                  accept;
  logic                  busy;
  logic [IDX_W-1:0]      req_idx;

  logic [WAYS*TAG_W-1:0] rd_tags;
  logic [WAYS-1:0]       rd_valid, rd_dirty;
  logic [TREE_W-1:0]     rd_tree;

  logic                  lk_hit;
  logic [WAY_W-1:0]      lk_way;
  logic                  lk_vvalid, lk_vdirty;
  logic [TAG_W-1:0]      lk_vtag;
  logic [WAYS*TAG_W-1:0] new_tags;
  logic [WAYS-1:0]       new_valid, new_dirty;
  logic [TREE_W-1:0]     new_tree;

  // stage 1 moves on when the result register is free or being drained
  assign s1_fire     = s1_valid_q && (!rsp_valid_q || !rsp_stall_i);
  assign req_stall_o = busy || (s1_valid_q && !s1_fire);
  assign accept      = req_valid_i && !req_stall_o;
  assign req_idx     = req_i.address[OFF_W +: IDX_W];

  sactp_store #(
    .SETS   (SETS),
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .IDX_W  (IDX_W),
    .TREE_W (TREE_W)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (req_idx),
    .wr_en_i    (s1_fire),
    .wr_idx_i   (s1_idx_q),
    .wr_tags_i  (new_tags),
    .wr_valid_i (new_valid),
    .wr_dirty_i (new_dirty),
    .wr_tree_i  (new_tree),
    .rd_tags_o  (rd_tags),
    .rd_valid_o (rd_valid),
    .rd_dirty_o (rd_dirty),
    .rd_tree_o  (rd_tree),
    .busy_o     (busy)
  );

  sactp_lookup #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .TREE_W (TREE_W),
    .WAY_W  (WAY_W)
  ) u_lookup (
    .tags_i         (rd_tags),
    .valid_i        (rd_valid),
    .dirty_i        (rd_dirty),
    .tree_i         (rd_tree),
    .tag_i          (s1_tag_q),
    .command_i      (s1_cmd_q),
    .hit_o          (lk_hit),
    .way_o          (lk_way),
    .victim_valid_o (lk_vvalid),
    .victim_dirty_o (lk_vdirty),
    .victim_tag_o   (lk_vtag),
    .tags_o         (new_tags),
    .valid_o        (new_valid),
    .dirty_o        (new_dirty),
    .tree_o         (new_tree)
  );

  // totals including the access now leaving stage 1
  assign hit_cnt_d  = lk_hit ? hit_cnt_q + 1'b1 : hit_cnt_q;
  assign miss_cnt_d = lk_hit ? miss_cnt_q : miss_cnt_q + 1'b1;

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        rsp_valid_q <= 1'b1;
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q <= req_i.command;
      s1_idx_q <= req_idx;
      s1_tag_q <= req_i.address[ADDR_W-1 -: TAG_W];
    end
    if (s1_fire) begin
      rsp_q.hit          <= lk_hit;
      rsp_q.way          <= WAY_OUT_W'(lk_way);
      rsp_q.victim_valid <= lk_vvalid;
      rsp_q.victim_dirty <= lk_vdirty;
      rsp_q.victim_tag   <= VTAG_W'(lk_vtag);
      rsp_q.hit_count    <= hit_cnt_d;
      rsp_q.miss_count   <= miss_cnt_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the set-associative tag store with tree pseudo-lru:
// a short directed table, then random accesses aimed at a few crowded sets,
// each result compared field by field against a typed answer or an in-bench lookup model
// ----------------------------------------------------------------------------
module tb_top;
  import sactp_pkg::*;

  // geometry of the block under test, kept at its defaults
  localparam int SETS       = 64;
  localparam int LINE_BYTES = 64;
  localparam int WAYS       = 4;
  localparam int OFS_W      = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int TAG_W      = ADDR_W - OFS_W - SET_W;
  // the tree spans the next power of two at or above the way count
  localparam int TREE_SPAN  = (WAYS <= 1) ? 1 : (WAYS <= 2) ? 2 : (WAYS <= 4) ? 4 : 8;

  localparam int NUM_DIRECTED    = 22;
  localparam int NUM_PHASE_ITEMS = 600;
  localparam int NUM_LAST_ITEMS  = 700;
  localparam int TAG_POOL        = 12;
  // a long receiver hold-off so the pipeline fills and pushes back
  localparam int PRESSURE_CYCLES = 60;
  // two register stages, with some slack for anything arriving late
  localparam int DRAIN_CYCLES    = 8;
  // covers the clearing sweep after reset and the long hold-off many times
  localparam int WATCHDOG_LIMIT  = 1000;

  // what the bench knows about an access when it is accepted
  typedef struct {
    bit         typed;
    sactp_rsp_t rsp;
  } access_note_t;

  // one row of the directed table
  typedef struct {
    logic              command;
    logic [ADDR_W-1:0] address;
    bit                typed;
    sactp_rsp_t        rsp;
  } access_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       req_valid_i = 1'b0;
  logic       req_stall_o;
  sactp_req_t req_i       = '0;
  logic       rsp_valid_o;
  logic       rsp_stall_i = 1'b0;
  sactp_rsp_t rsp_o;

  set_assoc_cache_tag_plru_unit #(
    .SETS      (SETS),
    .LINE_BYTES(LINE_BYTES),
    .WAYS      (WAYS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i),
    .rsp_o      (rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // lookup model state: tags only ever read where the valid bit is set
  logic [TAG_W-1:0]      line_tag   [SETS][WAYS];
  bit                    line_valid [SETS][WAYS];
  bit                    line_dirty [SETS][WAYS];
  logic [TREE_MAX_W-1:0] plru_bits  [SETS];
  logic [CNT_W-1:0]      hit_total  = '0;
  logic [CNT_W-1:0]      miss_total = '0;

  access_note_t access_q [$];   // driven but not yet accepted
  sactp_rsp_t   lookup_q [$];   // expected lookup results, oldest first
  logic [TAG_W-1:0] tag_pool [TAG_POOL];

  int unsigned failures       = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_go    = 1'b0;

  initial begin
    foreach (line_valid[s, w]) begin
      line_valid[s][w] = 1'b0;
      line_dirty[s][w] = 1'b0;
    end
    foreach (plru_bits[s]) plru_bits[s] = '0;
  end

  // walk the tree from the root; a branch that holds only absent ways is never taken
  function automatic int unsigned plru_victim(input logic [TREE_MAX_W-1:0] tree);
    int unsigned node, lo, span, half, go_up;
    node = 1;
    lo   = 0;
    span = TREE_SPAN;
    while (span > 1) begin
      half  = span >> 1;
      go_up = tree[node-1];
      if (lo + half >= WAYS) go_up = 0;
      if (go_up != 0) lo += half;
      node = node * 2 + go_up;
      span = half;
    end
    return lo;
  endfunction

  // point every node on the way's path away from it
  function automatic logic [TREE_MAX_W-1:0] plru_touch(input logic [TREE_MAX_W-1:0] tree,
                                                      input int unsigned way);
    int unsigned node, lo, span, half, up;
    node = 1;
    lo   = 0;
    span = TREE_SPAN;
    while (span > 1) begin
      half         = span >> 1;
      up           = (way - lo >= half) ? 1 : 0;
      tree[node-1] = (up == 0);
      if (up != 0) lo += half;
      node = node * 2 + up;
      span = half;
    end
    return tree;
  endfunction

  // one access against the model: tag compare, fill on miss, tree and counter update
  function automatic sactp_rsp_t lookup_line(input sactp_req_t acc);
    sactp_rsp_t       res;
    int unsigned      set_idx, w;
    logic [TAG_W-1:0] tag;
    res     = '0;
    set_idx = acc.address[OFS_W +: SET_W];
    tag     = acc.address[ADDR_W-1 -: TAG_W];
    for (w = 0; w < WAYS; w++) begin
      if (!res.hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        res.hit = 1'b1;
        res.way = WAY_OUT_W'(w);
      end
    end
    if (res.hit) begin
      hit_total++;
      if (acc.command == CMD_WRITE) line_dirty[set_idx][res.way] = 1'b1;
    end else begin
      miss_total++;
      w = plru_victim(plru_bits[set_idx]);
      if (w >= WAYS) w = 0;
      res.way = WAY_OUT_W'(w);
      // an invalid victim leaves all victim fields at zero
      if (line_valid[set_idx][w]) begin
        res.victim_valid = 1'b1;
        res.victim_dirty = line_dirty[set_idx][w];
        res.victim_tag   = VTAG_W'(line_tag[set_idx][w]);
      end
      line_tag[set_idx][w]   = tag;
      line_valid[set_idx][w] = 1'b1;
      line_dirty[set_idx][w] = (acc.command == CMD_WRITE);
    end
    plru_bits[set_idx] = plru_touch(plru_bits[set_idx], res.way);
    res.hit_count  = hit_total;
    res.miss_count = miss_total;
    return res;
  endfunction

  task automatic flag_field(input string name, input logic [CNT_W-1:0] want,
                            input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      failures++;
    end
  endtask

  // monitor: transactions counted at the rising edge, request side first so a
  // result can never overtake its own expectation
  always @(posedge clk_i) begin : monitor_p
    bit           moved;
    access_note_t note;
    sactp_rsp_t   predicted, want;
    int unsigned  idle_cycles;
    if (rst_ni) begin
      moved = 1'b0;
      if (req_valid_i && !req_stall_o) begin
        moved     = 1'b1;
        note      = access_q.pop_front();
        predicted = lookup_line(req_i);
        // typed rows carry their own answer; the model still tracks the state
        lookup_q.push_back(note.typed ? note.rsp : predicted);
      end
      if (rsp_valid_o && !rsp_stall_i) begin
        moved = 1'b1;
        if (lookup_q.size() == 0) begin
          $error("lookup result with no access outstanding");
          failures++;
        end else begin
          want = lookup_q.pop_front();
          flag_field("hit",          want.hit,          rsp_o.hit);
          flag_field("way",          want.way,          rsp_o.way);
          flag_field("victim_valid", want.victim_valid, rsp_o.victim_valid);
          flag_field("victim_dirty", want.victim_dirty, rsp_o.victim_dirty);
          flag_field("victim_tag",   want.victim_tag,   rsp_o.victim_tag);
          flag_field("hit_count",    want.hit_count,    rsp_o.hit_count);
          flag_field("miss_count",   want.miss_count,   rsp_o.miss_count);
        end
      end
      // watchdog on cycles without any transaction
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // receiver: random stall per falling edge, or one long hold-off on request
  initial begin : receiver_p
    forever begin
      @(negedge clk_i);
      if (pressure_go) begin
        pressure_go = 1'b0;
        rsp_stall_i <= 1'b1;
        repeat (PRESSURE_CYCLES - 1) @(negedge clk_i);
      end else begin
        rsp_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // offer one transaction from a falling edge and hold it until taken;
  // returns at the falling edge after acceptance
  task automatic drive_access(input sactp_req_t acc, input bit typed,
                              input sactp_rsp_t typed_rsp);
    access_note_t note;
    note.typed = typed;
    note.rsp   = typed_rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    access_q.push_back(note);
    req_valid_i <= 1'b1;
    req_i       <= acc;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly a few sets crowded with more tags than ways, so hits, dirty
  // evictions and tree walks all happen; the rest spreads over the space
  function automatic sactp_req_t make_access();
    sactp_req_t  acc;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    acc.command   = 1'($urandom_range(0, 1));
    acc.address   = $urandom;
    if (pick < 70) begin
      acc.address[OFS_W +: SET_W]       = SET_W'($urandom_range(0, 3));
      acc.address[ADDR_W-1 -: TAG_W]    = tag_pool[$urandom_range(0, 5)];
    end else if (pick < 90) begin
      acc.address[ADDR_W-1 -: TAG_W]    = tag_pool[$urandom_range(0, TAG_POOL - 1)];
    end
    return acc;
  endfunction

  // directed table: first rows typed from the reset state, the rest left to
  // the model (set 0 filled past its ways, dirty lines evicted, far sets)
  access_row_t directed_rows [NUM_DIRECTED] = '{
    // cold miss into way 0, then hits on the same line
    '{CMD_READ,  32'h0000_0000, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 20'h0, 32'd0, 32'd1}},
    '{CMD_READ,  32'h0000_003F, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b0, 20'h0, 32'd1, 32'd1}},
    '{CMD_WRITE, 32'h0000_0010, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b0, 20'h0, 32'd2, 32'd1}},
    // top of the address space: last set, all-ones tag
    '{CMD_WRITE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 3'd0, 1'b0, 1'b0, 20'h0, 32'd2, 32'd2}},
    '{CMD_READ,  32'hFFFF_FFC0, 1'b1, '{1'b1, 3'd0, 1'b0, 1'b0, 20'h0, 32'd3, 32'd2}},
    '{CMD_WRITE, 32'h0000_1000, 1'b0, '0},
    '{CMD_READ,  32'h0000_2000, 1'b0, '0},
    '{CMD_WRITE, 32'h8000_0000, 1'b0, '0},
    '{CMD_READ,  32'h0000_1004, 1'b0, '0},
    '{CMD_READ,  32'h0000_3000, 1'b0, '0},
    '{CMD_WRITE, 32'h0000_4000, 1'b0, '0},
    '{CMD_READ,  32'h0000_5000, 1'b0, '0},
    '{CMD_READ,  32'h0000_0000, 1'b0, '0},
    '{CMD_WRITE, 32'hFFFF_F000, 1'b0, '0},
    '{CMD_READ,  32'h0000_0FC0, 1'b0, '0},
    '{CMD_WRITE, 32'h0000_0FFF, 1'b0, '0},
    '{CMD_READ,  32'h7FFF_F040, 1'b0, '0},
    '{CMD_WRITE, 32'h0000_2008, 1'b0, '0},
    '{CMD_READ,  32'h5555_5555, 1'b0, '0},
    '{CMD_WRITE, 32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_READ,  32'h0000_6000, 1'b0, '0},
    '{CMD_WRITE, 32'h0000_7000, 1'b0, '0}
  };

  initial begin : stimulus_p
    sactp_req_t acc;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom);

    // reset held low at the start, released on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles often, receiver stalls half the time
    send_idle_pct  = 35;
    recv_stall_pct = 50;
    foreach (directed_rows[i]) begin
      acc.command = directed_rows[i].command;
      acc.address = directed_rows[i].address;
      drive_access(acc, directed_rows[i].typed, directed_rows[i].rsp);
    end
    repeat (NUM_PHASE_ITEMS) drive_access(make_access(), 1'b0, '0);

    // roles swapped
    send_idle_pct  = 50;
    recv_stall_pct = 35;
    repeat (NUM_PHASE_ITEMS) drive_access(make_access(), 1'b0, '0);

    // full rate, opened by a long receiver hold-off so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_go    = 1'b1;
    repeat (NUM_LAST_ITEMS) drive_access(make_access(), 1'b0, '0);
    req_valid_i <= 1'b0;

    // drain, then a short tail to catch anything extra
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
